### src/invoke_id_remap_table_core_defines.svh
// ----------------------------------------------------------------------------
// Invoke ID remap table - assertion macros
// Shared property macros for the remap table core checks.
// ----------------------------------------------------------------------------
`ifndef INVOKE_ID_REMAP_TABLE_CORE_DEFINES_SVH
`define INVOKE_ID_REMAP_TABLE_CORE_DEFINES_SVH

// same-cycle implication
`define IIRT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define IIRT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/iirt_pkg.sv
// ----------------------------------------------------------------------------
// Invoke ID remap table - package
// Field widths, result kinds, table entry and controller/datapath structs.
// ----------------------------------------------------------------------------
package iirt_pkg;

    localparam int PORT_W  = 8;
    localparam int ORIG_W  = 16;
    localparam int GEN_W   = 15;
    localparam int TDATA_W = 40;

    typedef enum logic [1:0] {
        KIND_ASSIGNED = 2'd0,
        KIND_ROUTED   = 2'd1,
        KIND_NO_MATCH = 2'd2,
        KIND_FULL     = 2'd3
    } kind_t;

    typedef struct packed {
        logic [PORT_W-1:0] port;
        logic [ORIG_W-1:0] orig;
        logic [GEN_W-1:0]  gen;
    } entry_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;    // latch input transaction, restart scan
        logic request;    // run request: append entry or report full
        logic scan_step;  // consume one scanned entry
        logic finish;     // emit final result of a response, commit fill
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_free;   // output register can load this cycle
        logic fill_zero;  // table empty
        logic match;      // scanned entry matches response ID
        logic pend_valid; // a routed result is held back
        logic scan_last;  // scanned entry is the last valid one
    } dp_stat_t;

endpackage

### src/iirt_ctrl.sv
// ----------------------------------------------------------------------------
// Invoke ID remap table - controller
// Sequences request handling and the response table scan.
// ----------------------------------------------------------------------------
module iirt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_op,
    output logic              in_ready,
    input  iirt_pkg::dp_stat_t stat,
    output iirt_pkg::dp_cmd_t  cmd
);
    import iirt_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REQ,
        ST_SCAN_RD,
        ST_SCAN_EV,
        ST_FINAL
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    if (!in_op)
                        state_next = ST_REQ;
                    else if (stat.fill_zero)
                        state_next = ST_FINAL;
                    else
                        state_next = ST_SCAN_RD;
                end
            end
            ST_REQ:
            begin
                if (stat.out_free)
                begin
                    cmd.request = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_SCAN_RD:
            begin
                state_next = ST_SCAN_EV;
            end
            ST_SCAN_EV:
            begin
                // a held-back result must leave before a new match replaces it
                if (!(stat.match && stat.pend_valid && !stat.out_free))
                begin
                    cmd.scan_step = 1'b1;
                    state_next    = stat.scan_last ? ST_FINAL : ST_SCAN_RD;
                end
            end
            ST_FINAL:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= (state_next == ST_IDLE);
        end
    end

    assign in_ready = ready_reg;

endmodule

### src/iirt_dpath.sv
// ----------------------------------------------------------------------------
// Invoke ID remap table - datapath
// Entry memory, fill count, ID counter, scan pointers and output register.
// ----------------------------------------------------------------------------
module iirt_dpath #(
    parameter int unsigned TABLE_DEPTH = 16,
    parameter int unsigned ID_LIMIT    = 32767
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [iirt_pkg::TDATA_W-1:0]  in_data,
    input  iirt_pkg::dp_cmd_t             cmd,
    output iirt_pkg::dp_stat_t            stat,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [iirt_pkg::TDATA_W-1:0]  out_data,
    output logic [1:0]                    out_kind,
    output logic                          out_last
);
    import iirt_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    entry_t mem [TABLE_DEPTH];
    entry_t rdata_reg;

    logic [PORT_W-1:0] port_reg;
    logic [ORIG_W-1:0] orig_reg;
    logic [GEN_W-1:0]  gen_reg;

    logic [CNT_W-1:0]  fill_reg,  fill_next;
    logic [GEN_W-1:0]  id_reg,    id_next;
    logic [IDX_W-1:0]  rd_reg,    rd_next;
    logic [CNT_W-1:0]  keep_reg,  keep_next;
    logic              pend_reg,  pend_next;
    logic [PORT_W-1:0] pport_reg;
    logic [ORIG_W-1:0] porig_reg;

    logic              oval_reg,  oval_next;
    kind_t             okind_reg, okind_next;
    logic [PORT_W-1:0] oport_reg, oport_next;
    logic [ORIG_W-1:0] oorig_reg, oorig_next;
    logic [GEN_W-1:0]  ogen_reg,  ogen_next;
    logic              olast_reg, olast_next;

    logic              out_free, full, match, out_load;
    logic [GEN_W-1:0]  id_step;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    entry_t            wr_data;

    assign out_free = !oval_reg || out_ready;
    assign full     = (fill_reg == CNT_W'(TABLE_DEPTH));
    assign match    = (rdata_reg.gen == gen_reg);
    // wraps from ID_LIMIT to 1; above the 15-bit range it wraps through 0
    assign id_step  = ({1'b0, id_reg} == 16'(ID_LIMIT)) ? GEN_W'(1) : id_reg + GEN_W'(1);

    assign stat.out_free   = out_free;
    assign stat.fill_zero  = (fill_reg == '0);
    assign stat.match      = match;
    assign stat.pend_valid = pend_reg;
    assign stat.scan_last  = ((CNT_W'(rd_reg) + CNT_W'(1)) == fill_reg);

    always_comb
    begin
        fill_next  = fill_reg;
        id_next    = id_reg;
        rd_next    = rd_reg;
        keep_next  = keep_reg;
        pend_next  = pend_reg;
        out_load   = 1'b0;
        okind_next = okind_reg;
        oport_next = oport_reg;
        oorig_next = oorig_reg;
        ogen_next  = ogen_reg;
        olast_next = olast_reg;
        wr_en      = 1'b0;
        wr_addr    = fill_reg[IDX_W-1:0];
        wr_data    = '{port: port_reg, orig: orig_reg, gen: id_step};

        if (cmd.capture)
        begin
            rd_next   = '0;
            keep_next = '0;
            pend_next = 1'b0;
        end

        if (cmd.request)
        begin
            out_load   = 1'b1;
            oport_next = '0;
            oorig_next = '0;
            olast_next = 1'b1;
            if (full)
            begin
                okind_next = KIND_FULL;
                ogen_next  = '0;
            end
            else
            begin
                okind_next = KIND_ASSIGNED;
                ogen_next  = id_step;
                id_next    = id_step;
                fill_next  = fill_reg + CNT_W'(1);
                wr_en      = 1'b1;
            end
        end

        if (cmd.scan_step)
        begin
            rd_next = rd_reg + IDX_W'(1);
            if (match)
            begin
                // release the previous match, hold this one back
                if (pend_reg)
                begin
                    out_load   = 1'b1;
                    okind_next = KIND_ROUTED;
                    oport_next = pport_reg;
                    oorig_next = porig_reg;
                    ogen_next  = gen_reg;
                    olast_next = 1'b0;
                end
                pend_next = 1'b1;
            end
            else
            begin
                wr_en     = 1'b1;
                wr_addr   = keep_reg[IDX_W-1:0];
                wr_data   = rdata_reg;
                keep_next = keep_reg + CNT_W'(1);
            end
        end

        if (cmd.finish)
        begin
            out_load   = 1'b1;
            ogen_next  = gen_reg;
            olast_next = 1'b1;
            fill_next  = keep_reg;
            pend_next  = 1'b0;
            if (pend_reg)
            begin
                okind_next = KIND_ROUTED;
                oport_next = pport_reg;
                oorig_next = porig_reg;
            end
            else
            begin
                okind_next = KIND_NO_MATCH;
                oport_next = '0;
                oorig_next = '0;
            end
        end

        oval_next = out_load ? 1'b1 : (out_ready ? 1'b0 : oval_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            id_reg   <= '0;
            rd_reg   <= '0;
            keep_reg <= '0;
            pend_reg <= 1'b0;
            oval_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            id_reg   <= id_next;
            rd_reg   <= rd_next;
            keep_reg <= keep_next;
            pend_reg <= pend_next;
            oval_reg <= oval_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            port_reg <= in_data[PORT_W-1:0];
            orig_reg <= in_data[PORT_W+ORIG_W-1:PORT_W];
            gen_reg  <= in_data[PORT_W+ORIG_W+GEN_W-1:PORT_W+ORIG_W];
        end
        if (cmd.scan_step && match)
        begin
            pport_reg <= rdata_reg.port;
            porig_reg <= rdata_reg.orig;
        end
        if (out_load)
        begin
            okind_reg <= okind_next;
            oport_reg <= oport_next;
            oorig_reg <= oorig_next;
            ogen_reg  <= ogen_next;
            olast_reg <= olast_next;
        end
    end

    // entry memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rdata_reg <= mem[rd_reg];
    end

    assign out_valid = oval_reg;
    assign out_kind  = okind_reg;
    assign out_last  = olast_reg;
    assign out_data  = {(TDATA_W - PORT_W - ORIG_W - GEN_W)'(0), ogen_reg, oorig_reg, oport_reg};

endmodule

### src/invoke_id_remap_table_core.sv
// ----------------------------------------------------------------------------
// Invoke ID remap table core
// Maps client invoke IDs to generated IDs on requests and routes server
// responses back to every client entry that holds the generated ID.
// ----------------------------------------------------------------------------
//
//  channel   dir   tdata (low bit up)                          tuser      tlast
//  s_*       in    client_port, original_id, generated_id      operation  -
//  m_*       out   dest_port, restored_id, assigned_id         kind       last
//
//  Request: accept, then table append once the output register is free.
//  Response: accept, then per valid entry a read and an evaluate state (the
//  entry memory has a single registered read port), then the final result.
//  Reset is asynchronous and clears the fill count, ID counter and output
//  valid; the entry memory is not cleared. A stalled m_tready holds the
//  controller only where it must load the output register or release a
//  held-back match; one input transaction is in flight at a time.
//
`include "invoke_id_remap_table_core_defines.svh"

module invoke_id_remap_table_core #(
    parameter int unsigned TABLE_DEPTH = 16,
    parameter int unsigned ID_LIMIT    = 32767
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // client_port[7:0], original_id[23:8], generated_id[38:24], zero pad
    input  logic [iirt_pkg::TDATA_W-1:0] s_tdata,
    // operation[0]: 0 request, 1 response
    input  logic [0:0]                   s_tuser,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // dest_port[7:0], restored_id[23:8], assigned_id[38:24], zero pad
    output logic [iirt_pkg::TDATA_W-1:0] m_tdata,
    // kind[1:0]
    output logic [1:0]                   m_tuser,
    output logic                         m_tlast,
    output logic                         m_tvalid,
    input  logic                         m_tready
);
    import iirt_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    iirt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_op    (s_tuser[0]),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    iirt_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ID_LIMIT    (ID_LIMIT)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_kind  (m_tuser),
        .out_last  (m_tlast)
    );

    // only routed results can be followed by more results of the same transaction
    `IIRT_ASSERT_NOW(a_nonlast_routed, m_tvalid && !m_tlast, m_tuser == KIND_ROUTED, "non-last result is not routed")
    // one transaction in flight: busy right after an accept
    `IIRT_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready after accept")
    // a held-back match is never dropped over a busy output register
    `IIRT_ASSERT_NOW(a_pend_not_lost, cmd.scan_step && stat.match && stat.pend_valid, stat.out_free, "pending result overwritten")

endmodule

### bench/invoke_id_remap_table_core_tb.sv
// ----------------------------------------------------------------------------
// Invoke ID remap table core - testbench
// Sends client requests and server responses into the core and checks every
// result transaction against an in-bench model of the remap table. The model
// tracks the generated ID counter and the ordered entry list. The run covers
// the empty table, a full table, matches in the middle of the table, slot
// reuse after a retire, and a back-to-back run that retires newest first.
// Both sides of the core see random gaps and stalls.
// ----------------------------------------------------------------------------
module invoke_id_remap_table_core_tb;

    import iirt_pkg::*;

    localparam int unsigned TABLE_DEPTH = 16;
    localparam int unsigned ID_LIMIT    = 32767;
    localparam int unsigned RANDOM_TXNS = 60;
    // cycles with no transaction on either side before the run is abandoned
    localparam int unsigned STALL_LIMIT = 1000;
    // settle time after the last result: one full table scan plus margin
    localparam int unsigned TAIL_CYCLES = 50;

    localparam logic OP_REQUEST  = 1'b0;
    localparam logic OP_RESPONSE = 1'b1;

    // one input transaction, as the client/server side sees it
    typedef struct packed {
        logic              op;
        logic [PORT_W-1:0] port;
        logic [ORIG_W-1:0] orig;
        logic [GEN_W-1:0]  gen;
    } remap_txn_t;

    // one result transaction the core should produce
    typedef struct {
        kind_t             kind;
        logic [PORT_W-1:0] dest_port;
        logic [ORIG_W-1:0] restored_id;
        logic [GEN_W-1:0]  assigned_id;
        logic              last;
    } route_result_t;

    // ------------------------------------------------------------------------
    // DUT signals; every input has a known value from time zero
    // ------------------------------------------------------------------------
    logic               clk      = 1'b0;
    logic               rst_n    = 1'b0;
    logic [TDATA_W-1:0] s_tdata  = '0;
    logic [0:0]         s_tuser  = '0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [TDATA_W-1:0] m_tdata;
    logic [1:0]         m_tuser;
    logic               m_tlast;
    logic               m_tvalid;
    logic               m_tready = 1'b0;

    // ------------------------------------------------------------------------
    // Table model: counter and ordered entry list, updated on each accepted
    // input transaction; results are queued in the order the core emits them
    // ------------------------------------------------------------------------
    logic [GEN_W-1:0] gen_counter = '0;
    entry_t           remap_entries[$];
    route_result_t    expected_routes[$];

    // stimulus handoff between the sequence and the driver
    remap_txn_t  pending_txns[$];
    int unsigned txns_queued = 0;
    int unsigned txns_taken  = 0;
    logic        s_taken     = 1'b0;

    // driver/receiver pacing
    logic        burst_mode  = 1'b0;   // no gaps, no stalls (used for the retire run)
    int unsigned burst_left  = 4;
    int unsigned gap_left    = 0;
    logic        ready_level = 1'b0;
    int unsigned ready_run   = 0;

    // bookkeeping
    int unsigned mismatches = 0;
    int unsigned n_requests = 0;
    int unsigned n_responses = 0;
    int unsigned n_assigned = 0;
    int unsigned n_routed = 0;
    int unsigned n_no_match = 0;
    int unsigned n_full = 0;
    int unsigned max_hits = 0;
    int unsigned id_wraps = 0;
    int unsigned idle_cycles = 0;

    invoke_id_remap_table_core #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ID_LIMIT    (ID_LIMIT)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void queue_route(kind_t kind, logic [PORT_W-1:0] port,
                                        logic [ORIG_W-1:0] orig,
                                        logic [GEN_W-1:0] gen, logic last);
        route_result_t r;
        r.kind        = kind;
        r.dest_port   = port;
        r.restored_id = orig;
        r.assigned_id = gen;
        r.last        = last;
        expected_routes.push_back(r);
    endfunction

    // Apply one accepted transaction to the table model.
    // Request: append with the next ID, or report full and leave the counter.
    // Response: emit every matching entry oldest first, keep the rest in order.
    function automatic void remap_predict(remap_txn_t txn);
        entry_t      kept[$];
        entry_t      fresh;
        int unsigned hit_total;
        int unsigned hit_seen;
        hit_total = 0;
        hit_seen  = 0;
        if (txn.op == OP_REQUEST)
        begin
            n_requests++;
            if (remap_entries.size() >= TABLE_DEPTH)
            begin
                queue_route(KIND_FULL, '0, '0, '0, 1'b1);
                n_full++;
            end
            else
            begin
                if (gen_counter == GEN_W'(ID_LIMIT))
                begin
                    gen_counter = GEN_W'(1);
                    id_wraps++;
                end
                else
                begin
                    gen_counter = gen_counter + 1'b1;
                end
                fresh.port = txn.port;
                fresh.orig = txn.orig;
                fresh.gen  = gen_counter;
                remap_entries.push_back(fresh);
                queue_route(KIND_ASSIGNED, '0, '0, gen_counter, 1'b1);
                n_assigned++;
            end
        end
        else
        begin
            n_responses++;
            foreach (remap_entries[i])
                if (remap_entries[i].gen == txn.gen)
                    hit_total++;
            foreach (remap_entries[i])
            begin
                if (remap_entries[i].gen == txn.gen)
                begin
                    hit_seen++;
                    queue_route(KIND_ROUTED, remap_entries[i].port, remap_entries[i].orig,
                                txn.gen, hit_seen == hit_total);
                end
                else
                begin
                    kept.push_back(remap_entries[i]);
                end
            end
            remap_entries = kept;
            if (hit_total == 0)
            begin
                queue_route(KIND_NO_MATCH, '0, '0, txn.gen, 1'b1);
                n_no_match++;
            end
            n_routed += hit_total;
            if (hit_total > max_hits)
                max_hits = hit_total;
        end
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: model update on input transactions, compare on result ones.
    // Outputs are sampled at the rising edge; inputs only move on the falling.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        route_result_t want;
        remap_txn_t    seen;
        if (rst_n)
        begin
            s_taken = s_tvalid && s_tready;
            if (s_taken)
            begin
                seen.op   = s_tuser[0];
                seen.port = s_tdata[7:0];
                seen.orig = s_tdata[23:8];
                seen.gen  = s_tdata[38:24];
                remap_predict(seen);
                txns_taken++;
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_routes.size() == 0)
                begin
                    $error("result with nothing expected: kind %0d, tdata 0x%0h, tlast %0b",
                           m_tuser, m_tdata, m_tlast);
                    mismatches++;
                end
                else
                begin
                    want = expected_routes.pop_front();
                    check_field("kind", 16'(want.kind), 16'(m_tuser));
                    check_field("dest_port", 16'(want.dest_port), 16'(m_tdata[7:0]));
                    check_field("restored_id", want.restored_id, m_tdata[23:8]);
                    check_field("assigned_id", 16'(want.assigned_id), 16'(m_tdata[38:24]));
                    check_field("last", 16'(want.last), 16'(m_tlast));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driver: bursts of back-to-back transactions with random gaps between.
    // While idle the data lines carry junk so ignored bits get exercised.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        remap_txn_t txn;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else if (!s_tvalid || s_taken)
        begin
            if (gap_left > 0 || pending_txns.size() == 0)
            begin
                if (gap_left > 0)
                    gap_left--;
                s_tvalid <= 1'b0;
                s_tdata  <= TDATA_W'({$urandom, $urandom});
                s_tuser  <= 1'($urandom);
            end
            else
            begin
                txn = pending_txns.pop_front();
                s_tdata  <= {1'b0, txn.gen, txn.orig, txn.port};
                s_tuser  <= txn.op;
                s_tvalid <= 1'b1;
                if (burst_left > 1)
                begin
                    burst_left--;
                end
                else
                begin
                    burst_left = $urandom_range(1, 12);
                    gap_left   = burst_mode ? 0 : $urandom_range(0, 8);
                end
            end
        end
    end

    // Receiver: alternating runs of ready and stall of random length
    always @(negedge clk)
    begin
        if (burst_mode)
        begin
            m_tready <= 1'b1;
        end
        else
        begin
            if (ready_run == 0)
            begin
                ready_level = !ready_level;
                ready_run   = ready_level ? $urandom_range(1, 16) : $urandom_range(1, 10);
            end
            ready_run--;
            m_tready <= ready_level;
        end
    end

    // Watchdog: a hung handshake on either side ends the run
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("** invoke_id_remap_table_core: FAILED **");
            $finish;
        end
    end

    // hand one transaction to the driver and wait until the core takes it,
    // so the table model is current when the next one is chosen
    task automatic send(logic op, logic [PORT_W-1:0] port, logic [ORIG_W-1:0] orig,
                        logic [GEN_W-1:0] gen);
        remap_txn_t txn;
        txn.op   = op;
        txn.port = port;
        txn.orig = orig;
        txn.gen  = gen;
        pending_txns.push_back(txn);
        txns_queued++;
        wait (txns_taken == txns_queued);
    endtask

    // hold the sender until every outstanding result has come back
    task automatic drain_results();
        while (expected_routes.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned pick;
        logic [GEN_W-1:0] resp_id;

        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // empty table: both ID extremes find nothing
        send(OP_RESPONSE, 8'hFF, 16'hFFFF, 15'h0000);
        send(OP_RESPONSE, 8'h00, 16'h0000, 15'h7FFF);
        // port and original ID extremes; generated_id is a don't-care here
        send(OP_REQUEST, 8'h00, 16'h0000, 15'h7FFF);
        send(OP_REQUEST, 8'hFF, 16'hFFFF, 15'h0000);
        send(OP_REQUEST, 8'h5A, 16'hA5C3, 15'h2AAA);
        // match in the middle (table compacts), then the same ID again
        send(OP_RESPONSE, 8'h00, 16'h0000, 15'd2);
        send(OP_RESPONSE, 8'hFF, 16'hFFFF, 15'd2);
        send(OP_RESPONSE, 8'h3C, 16'h0F0F, 15'd1);
        drain_results();

        // fill every slot, then one request too many
        while (remap_entries.size() < TABLE_DEPTH)
            send(OP_REQUEST, PORT_W'($urandom), ORIG_W'($urandom), GEN_W'($urandom));
        send(OP_REQUEST, 8'h81, 16'h8001, 15'h4000);
        // retire the newest entry and reuse its slot
        send(OP_RESPONSE, PORT_W'($urandom), ORIG_W'($urandom),
             remap_entries[TABLE_DEPTH-1].gen);
        send(OP_REQUEST, PORT_W'($urandom), ORIG_W'($urandom), GEN_W'($urandom));
        drain_results();

        // back-to-back run with no stalls: retire newest first down to two
        burst_mode = 1'b1;
        while (remap_entries.size() > 2)
            send(OP_RESPONSE, PORT_W'($urandom), ORIG_W'($urandom),
                 remap_entries[remap_entries.size()-1].gen);
        drain_results();
        burst_mode = 1'b0;

        // random traffic: responses mostly target live IDs, the rest are
        // stray IDs; a pause every 30 items
        for (int unsigned n = 0; n < RANDOM_TXNS; n++)
        begin
            if (n % 30 == 29)
                drain_results();
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                send(OP_REQUEST, PORT_W'($urandom), ORIG_W'($urandom), GEN_W'($urandom));
            end
            else
            begin
                if (remap_entries.size() != 0 && pick < 88)
                    resp_id = remap_entries[$urandom_range(0, remap_entries.size()-1)].gen;
                else
                    resp_id = GEN_W'($urandom);
                send(OP_RESPONSE, PORT_W'($urandom), ORIG_W'($urandom), resp_id);
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("run: %0d requests (%0d IDs issued, %0d table-full), %0d responses",
                 n_requests, n_assigned, n_full, n_responses);
        $display("run: %0d routed, %0d unmatched, up to %0d hits per response, %0d ID wraps",
                 n_routed, n_no_match, max_hits, id_wraps);
        if (mismatches == 0)
            $display("** invoke_id_remap_table_core: PASSED **");
        else
            $display("** invoke_id_remap_table_core: FAILED **");
        $finish;
    end

endmodule

### filelist.f
+incdir+src
src/iirt_pkg.sv
src/iirt_ctrl.sv
src/iirt_dpath.sv
src/invoke_id_remap_table_core.sv
bench/invoke_id_remap_table_core_tb.sv
